/* hdl/led_pattern_sequencer_macros.svh */
// assertion macros used by the checker file
`ifndef LED_PATTERN_SEQUENCER_MACROS_SVH
`define LED_PATTERN_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on clk, idle while rst is high
`define LPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lps assertion failed");

// next-cycle implication, sampled on clk, idle while rst is high
`define LPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lps assertion failed");

`endif

/* hdl/lps_pkg.sv */
package lps_pkg;

  // register indexes on the configuration channel
  localparam logic [1:0] REG_FIXED_PATTERN = 2'd0;
  localparam logic [1:0] REG_FIXED_MASK    = 2'd1;

  // led bits
  localparam logic [3:0] LED_Y = 4'b0001;
  localparam logic [3:0] LED_B = 4'b0010;
  localparam logic [3:0] LED_G = 4'b0100;
  localparam logic [3:0] LED_R = 4'b1000;

  typedef struct packed {
    logic [3:0] fixed_pattern;
    logic [3:0] fixed_mask;
  } cfg_t;

  // number of steps in each pattern
  function automatic logic [2:0] seq_len(input logic [2:0] sel);
    logic [2:0] len;
    case (sel)
      3'd0:    len = 3'd4;
      3'd1:    len = 3'd6;
      3'd2:    len = 3'd2;
      3'd3:    len = 3'd2;
      3'd4:    len = 3'd2;
      3'd5:    len = 3'd5;
      3'd6:    len = 3'd6;
      3'd7:    len = 3'd7;
      default: len = 3'd2;
    endcase
    return len;
  endfunction

  // led word of one step; unused steps read as all off
  function automatic logic [3:0] seq_word(input logic [2:0] sel, input logic [2:0] step);
    logic [3:0] w;
    w = 4'b0000;
    case (sel)
      3'd0: begin
        case (step)
          3'd0: w = LED_Y;
          3'd1: w = LED_B;
          3'd2: w = LED_G;
          3'd3: w = LED_R;
          default: w = 4'b0000;
        endcase
      end
      3'd1: begin
        case (step)
          3'd0: w = LED_Y;
          3'd1: w = LED_B;
          3'd2: w = LED_G;
          3'd3: w = LED_R;
          3'd4: w = LED_G;
          3'd5: w = LED_B;
          default: w = 4'b0000;
        endcase
      end
      3'd2: w = (step == 3'd0) ? LED_R : 4'b0000;
      3'd3: begin
        case (step)
          3'd0: w = LED_Y | LED_R;
          3'd1: w = LED_B | LED_G;
          default: w = 4'b0000;
        endcase
      end
      3'd4: w = (step == 3'd0) ? (LED_Y | LED_B | LED_G | LED_R) : 4'b0000;
      3'd5: begin
        case (step)
          3'd0: w = LED_R;
          3'd1: w = LED_G;
          3'd2: w = LED_B;
          3'd3: w = LED_Y;
          default: w = 4'b0000;
        endcase
      end
      3'd6: begin
        case (step)
          3'd0: w = LED_R;
          3'd1: w = LED_G | LED_R;
          3'd2: w = LED_B | LED_G;
          3'd3: w = LED_Y | LED_B;
          3'd4: w = LED_Y;
          default: w = 4'b0000;
        endcase
      end
      3'd7: begin
        case (step)
          3'd0: w = LED_R;
          3'd1: w = LED_G | LED_R;
          3'd2: w = LED_B | LED_G | LED_R;
          3'd3: w = LED_Y | LED_B | LED_G;
          3'd4: w = LED_Y | LED_B;
          3'd5: w = LED_Y;
          default: w = 4'b0000;
        endcase
      end
      default: w = 4'b0000;
    endcase
    return w;
  endfunction

  // dwell of one step in ticks; pattern 0 steps last four, the blank tail step of patterns 5 to 7 lasts two
  function automatic logic [2:0] seq_dwell(input logic [2:0] sel, input logic [2:0] step);
    logic [2:0] d;
    case (sel)
      3'd0:    d = (step <= 3'd3) ? 3'd4 : 3'd1;
      3'd5:    d = (step == 3'd4) ? 3'd2 : 3'd1;
      3'd6:    d = (step == 3'd5) ? 3'd2 : 3'd1;
      3'd7:    d = (step == 3'd6) ? 3'd2 : 3'd1;
      default: d = 3'd1;
    endcase
    return d;
  endfunction

endpackage

/* hdl/lps_cfg_regs.sv */
module lps_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  output lps_pkg::cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  // register write decode, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_pattern <= 4'b0000;
      cfg.fixed_mask    <= 4'b0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        lps_pkg::REG_FIXED_PATTERN: cfg.fixed_pattern <= cfg_data;
        lps_pkg::REG_FIXED_MASK:    cfg.fixed_mask    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/lps_sequencer.sv */
module lps_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [2:0]    pattern_select,
  input  logic          button_fixed,
  input  logic          button_invert,
  input  lps_pkg::cfg_t cfg,
  output logic [3:0]    led_drive
);

  logic [2:0] last_pattern;
  logic [2:0] step_index;
  logic [2:0] dwell_count;
  logic [2:0] step_index_next;
  logic [2:0] dwell_count_next;

  logic       restart;
  logic [2:0] step_cur;
  logic [2:0] dwell_cur;
  logic [2:0] dwell_inc;
  logic [2:0] step_inc;
  logic [3:0] rom_word;
  logic [3:0] merged;
  logic [3:0] forced;

  // a new pattern starts from its first step
  assign restart   = (pattern_select != last_pattern);
  assign step_cur  = restart ? 3'd0 : step_index;
  assign dwell_cur = restart ? 3'd0 : dwell_count;

  // led word: pattern merged with fixed levels, then buttons
  assign rom_word  = lps_pkg::seq_word(pattern_select, step_cur);
  assign merged    = (rom_word & ~cfg.fixed_mask) | (cfg.fixed_pattern & cfg.fixed_mask);
  assign forced    = button_fixed ? cfg.fixed_pattern : merged;
  assign led_drive = button_invert ? ~forced : forced;

  // dwell and step advance, step wraps at the pattern length
  assign dwell_inc = dwell_cur + 3'd1;
  assign step_inc  = step_cur + 3'd1;

  always_comb begin
    step_index_next  = step_cur;
    dwell_count_next = dwell_inc;
    if (dwell_inc >= lps_pkg::seq_dwell(pattern_select, step_cur)) begin
      dwell_count_next = 3'd0;
      if ((step_cur == 3'd7) || (step_inc >= lps_pkg::seq_len(pattern_select))) begin
        step_index_next = 3'd0;
      end else begin
        step_index_next = step_inc;
      end
    end
  end

  // sequence state moves once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pattern <= 3'd0;
      step_index   <= 3'd0;
      dwell_count  <= 3'd0;
    end else if (advance) begin
      last_pattern <= pattern_select;
      step_index   <= step_index_next;
      dwell_count  <= dwell_count_next;
    end
  end

endmodule

/* hdl/led_pattern_sequencer.sv */
// each input transfer passes the input register and then the result register on its way to m_axis.
// throughput: one tick per cycle while m_axis does not stall; the step update between
// the input register and the result register is combinational.
// reset (rst, synchronous, active high) empties both registers, zeroes the
// fixed pattern and mask, and restarts the sequence at pattern 0, step 0.
module led_pattern_sequencer (
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  // tick input
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [2:0] pattern_select, [7:3] zero
  input  logic [1:0] s_axis_tuser,   // [0] button_fixed, [1] button_invert
  // led result
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] led_drive, [7:4] zero
);

  lps_pkg::cfg_t cfg;

  logic       in_valid;
  logic [2:0] in_select;
  logic       in_fixed;
  logic       in_invert;
  logic       advance;
  logic [3:0] led_word;
  logic [3:0] led_drive;

  lps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input stage moves on whenever the result register is free or drains
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_select <= s_axis_tdata[2:0];
      in_fixed  <= s_axis_tuser[0];
      in_invert <= s_axis_tuser[1];
    end
  end

  lps_sequencer u_seq (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .pattern_select (in_select),
    .button_fixed   (in_fixed),
    .button_invert  (in_invert),
    .cfg            (cfg),
    .led_drive      (led_word)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_drive <= led_word;
    end
  end

  assign m_axis_tdata = {4'b0000, led_drive};

endmodule

/* hdl/lps_checker.sv */
`include "led_pattern_sequencer_macros.svh"

module lps_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled result holds its value
  `LPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // upper result bits are padding
  `LPS_ASSERT_NOW(a_out_pad, m_axis_tvalid, m_axis_tdata[7:4] == 4'b0000)

  // with the result register empty the input side never stalls
  `LPS_ASSERT_NOW(a_in_ready, !m_axis_tvalid, s_axis_tready)

  // nothing appears on the output just after a reset cycle
  `LPS_ASSERT_NOW(a_reset_empty, $past(rst), !m_axis_tvalid)

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (.*);
